>>> src/cbos_pkg.sv
`timescale 1ns / 1ps

package cbos_pkg;

  localparam int COORD_W     = 24;
  localparam int WIDTH_W     = 16;
  localparam int IDX_W       = 7;
  localparam int IN_TDATA_W  = 216;
  localparam int OUT_TDATA_W = 96;
  localparam int OFS_W       = 17;
  localparam int ROOT_W      = 25;
  localparam int QUOT_W      = 25;

  localparam logic signed [26:0] COORD_MAX = 27'sd8388607;
  localparam logic signed [26:0] COORD_MIN = -27'sd8388608;

  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [26:0] v);
    logic [COORD_W-1:0] r;
    if (v > COORD_MAX) begin
      r = COORD_MAX[COORD_W-1:0];
    end else if (v < COORD_MIN) begin
      r = COORD_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> src/cubic_bezier_offset_sampler_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Payload
// in_      slave      four control points, half width and sample index
// out_     master     left and right offset points, degenerate flag in tuser
//
// One word is accepted every cycle while the pipeline advances; a result reaches the output register after
// passing through five arithmetic stages, the leading-zero normaliser, the square root and the offset
// dividers that resolve one bit per stage.
// The curve point division by SAMPLES cubed is a reciprocal multiplication over three stages.
// Reset clears the valid bits of every stage and of the output register, and holds in_tready low.
// The whole pipeline advances together; it holds while a result waits at the output.
module cubic_bezier_offset_sampler_core #(
  parameter int SAMPLES = 100
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // start_x, start_z, ctrl_a_x, ctrl_a_z, ctrl_b_x, ctrl_b_z, finish_x, finish_z,
  // offset_width, sample_index
  input  logic [cbos_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // left_x, left_z, right_x, right_z
  output logic [cbos_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // degenerate
  output logic                                 out_tuser
);

  localparam int KW  = $clog2(SAMPLES + 1);
  localparam int CW  = 3 * KW;
  localparam int PW  = CW + 25;
  localparam int NW  = CW + 26;
  localparam int TW  = 2 * KW + 27;
  localparam int DW  = 2 * KW + 29;
  localparam int NS  = $clog2(DW);
  localparam int T   = NS + 45;
  localparam longint DEN = longint'(SAMPLES) * longint'(SAMPLES) * longint'(SAMPLES);
  localparam logic signed [NW:0] BIAS = (NW + 1)'(DEN / 2 + (DEN << 24));
  localparam int RS  = 2 * CW + 26;
  localparam int RW  = CW + 30;
  localparam int NL  = (NW + 23) / 24;
  localparam int RL  = (RW + 23) / 24;
  localparam int AW  = 24 * RL + 24;
  localparam int PRW = 24 * (NL + RL);
  localparam logic [24*RL-1:0] RCP = (24 * RL)'(((128'd1 << RS) / 128'(DEN)) + 128'd1);

  typedef struct packed {
    logic                        deg;
    logic                        xneg;
    logic                        xpos;
    logic                        zneg;
    logic                        zpos;
    logic [cbos_pkg::WIDTH_W-1:0] w;
    logic [NW-1:0]               fxr;
    logic [NW-1:0]               fzr;
    logic [NL*RL-1:0][47:0]      ppx;
    logic [NL*RL-1:0][47:0]      ppz;
    logic [NL-1:0][AW-1:0]       rwx;
    logic [NL-1:0][AW-1:0]       rwz;
    logic [cbos_pkg::QUOT_W-1:0] fxq;
    logic [cbos_pkg::QUOT_W-1:0] fzq;
    logic [DW-1:0]               ax;
    logic [DW-1:0]               az;
    logic [49:0]                 sqn;
    logic [47:0]                 sq2;
    logic [27:0]                 sqr;
    logic [cbos_pkg::ROOT_W-1:0] sqq;
    logic [41:0]                 oxr;
    logic [41:0]                 ozr;
    logic [25:0]                 dv;
    logic [cbos_pkg::OFS_W-1:0]  oxq;
    logic [cbos_pkg::OFS_W-1:0]  ozq;
  } ctx_t;

  logic adv;
  logic out_tvalid_r;
  logic [cbos_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic out_tuser_r;

  assign adv        = !out_tvalid_r || out_tready;
  assign in_tready  = adv && rst_n;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  logic [4:0] vp_r;
  logic [T:0] v_r;

  // Input capture, sample index clamp.
  logic [KW-1:0] k_clamp;
  logic [31:0]   k32;
  assign k32     = 32'(in_tdata[214:208]);
  assign k_clamp = (k32 > 32'(SAMPLES)) ? KW'(SAMPLES) : KW'(k32);

  logic signed [23:0] px0_r [4];
  logic signed [23:0] pz0_r [4];
  logic [15:0]        w0_r;
  logic [KW-1:0]      k0_r;
  logic [KW-1:0]      u0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        px0_r[i] <= in_tdata[48*i +: 24];
        pz0_r[i] <= in_tdata[48*i+24 +: 24];
      end
      w0_r <= in_tdata[207:192];
      k0_r <= k_clamp;
      u0_r <= KW'(SAMPLES) - k_clamp;
    end
  end

  logic [2*KW-1:0]    uu1_r, kk1_r, uk1_r;
  logic [KW-1:0]      u1_r, k1_r;
  logic signed [23:0] px1_r [4];
  logic signed [23:0] pz1_r [4];
  logic signed [24:0] dx1_r [3];
  logic signed [24:0] dz1_r [3];
  logic [15:0]        w1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      uu1_r <= u0_r * u0_r;
      kk1_r <= k0_r * k0_r;
      uk1_r <= u0_r * k0_r;
      u1_r  <= u0_r;
      k1_r  <= k0_r;
      for (int i = 0; i < 4; i++) begin
        px1_r[i] <= px0_r[i];
        pz1_r[i] <= pz0_r[i];
      end
      for (int i = 0; i < 3; i++) begin
        dx1_r[i] <= 25'(px0_r[i]) - 25'(px0_r[i+1]);
        dz1_r[i] <= 25'(pz0_r[i]) - 25'(pz0_r[i+1]);
      end
      w1_r <= w0_r;
    end
  end

  logic [CW-1:0]      c2_r [4];
  logic [2*KW:0]      tc2_r [3];
  logic signed [23:0] px2_r [4];
  logic signed [23:0] pz2_r [4];
  logic signed [24:0] dx2_r [3];
  logic signed [24:0] dz2_r [3];
  logic [15:0]        w2_r;
  logic [CW-1:0]      cu3, cuk, ckk;

  always_comb begin
    cu3 = uu1_r * u1_r;
    cuk = uu1_r * k1_r;
    ckk = uk1_r * k1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_r[0]  <= cu3;
      c2_r[1]  <= cuk + (cuk << 1);
      c2_r[2]  <= ckk + (ckk << 1);
      c2_r[3]  <= kk1_r * k1_r;
      tc2_r[0] <= (2*KW+1)'(uu1_r);
      tc2_r[1] <= {uk1_r, 1'b0};
      tc2_r[2] <= (2*KW+1)'(kk1_r);
      px2_r    <= px1_r;
      pz2_r    <= pz1_r;
      dx2_r    <= dx1_r;
      dz2_r    <= dz1_r;
      w2_r     <= w1_r;
    end
  end

  logic signed [PW-1:0] prx3_r [4];
  logic signed [PW-1:0] prz3_r [4];
  logic signed [TW-1:0] tx3_r [3];
  logic signed [TW-1:0] tz3_r [3];
  logic [15:0]          w3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        prx3_r[i] <= $signed({1'b0, c2_r[i]}) * px2_r[i];
        prz3_r[i] <= $signed({1'b0, c2_r[i]}) * pz2_r[i];
      end
      for (int i = 0; i < 3; i++) begin
        tx3_r[i] <= $signed({1'b0, tc2_r[i]}) * dx2_r[i];
        tz3_r[i] <= $signed({1'b0, tc2_r[i]}) * dz2_r[i];
      end
      w3_r <= w2_r;
    end
  end

  logic signed [NW:0]   nx4_r, nz4_r;
  logic signed [DW-1:0] ddx4_r, ddz4_r;
  logic [15:0]          w4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      nx4_r  <= (NW+1)'(prx3_r[0]) + (NW+1)'(prx3_r[1]) + (NW+1)'(prx3_r[2])
              + (NW+1)'(prx3_r[3]) + BIAS;
      nz4_r  <= (NW+1)'(prz3_r[0]) + (NW+1)'(prz3_r[1]) + (NW+1)'(prz3_r[2])
              + (NW+1)'(prz3_r[3]) + BIAS;
      ddx4_r <= DW'(tx3_r[0]) + DW'(tx3_r[1]) + DW'(tx3_r[2]);
      ddz4_r <= DW'(tz3_r[0]) + DW'(tz3_r[1]) + DW'(tz3_r[2]);
      w4_r   <= w3_r;
    end
  end

  ctx_t ch_r [T+1];
  ctx_t ch0_nxt;

  always_comb begin
    ch0_nxt      = '0;
    ch0_nxt.deg  = (ddx4_r == '0) && (ddz4_r == '0);
    ch0_nxt.xneg = ddx4_r[DW-1];
    ch0_nxt.xpos = !ddx4_r[DW-1] && (ddx4_r != '0);
    ch0_nxt.zneg = ddz4_r[DW-1];
    ch0_nxt.zpos = !ddz4_r[DW-1] && (ddz4_r != '0);
    ch0_nxt.w    = w4_r;
    ch0_nxt.fxr  = nx4_r[NW-1:0];
    ch0_nxt.fzr  = nz4_r[NW-1:0];
    ch0_nxt.ax   = ddx4_r[DW-1] ? DW'(-ddx4_r) : DW'(ddx4_r);
    ch0_nxt.az   = ddz4_r[DW-1] ? DW'(-ddz4_r) : DW'(ddz4_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ch_r[0] <= ch0_nxt;
    end
  end

  for (genvar j = 0; j < T; j++) begin : g_stage
    localparam int SH = (j < NS) ? (1 << (NS - 1 - j)) : 1;
    localparam int OB = (j >= NS + 28) ? (16 - (j - NS - 28)) : 0;

    ctx_t c;
    ctx_t n;

    assign c = ch_r[j];

    always_comb begin
      logic [DW-1:0]    m;
      logic [23:0]      a24, b24;
      logic [47:0]      pa, pb;
      logic [27:0]      r2, tq;
      logic [39:0]      wax, waz;
      logic [42:0]      dsh;
      logic             ge;
      logic [24*NL-1:0] mxp, mzp;
      logic [AW-1:0]    acx, acz;
      logic [PRW-1:0]   smx, smz;
      n   = c;
      m   = c.ax | c.az;
      a24 = c.ax[DW-1 -: 24];
      b24 = c.az[DW-1 -: 24];
      pa  = a24 * a24;
      pb  = b24 * b24;
      r2  = {c.sqr[25:0], c.sqn[49:48]};
      tq  = {1'b0, c.sqq, 2'b01};
      wax = c.w * c.ax[23:0];
      waz = c.w * c.az[23:0];
      dsh = 43'(c.dv) << OB;
      ge  = 1'b0;
      mxp = (24 * NL)'(c.fxr);
      mzp = (24 * NL)'(c.fzr);
      acx = '0;
      acz = '0;
      smx = '0;
      smz = '0;
      if (j == 0) begin
        for (int a = 0; a < NL; a++) begin
          for (int b = 0; b < RL; b++) begin
            n.ppx[a*RL+b] = mxp[24*a +: 24] * RCP[24*b +: 24];
            n.ppz[a*RL+b] = mzp[24*a +: 24] * RCP[24*b +: 24];
          end
        end
      end else if (j == 1) begin
        for (int a = 0; a < NL; a++) begin
          acx = '0;
          acz = '0;
          for (int b = 0; b < RL; b++) begin
            acx = acx + (AW'(c.ppx[a*RL+b]) << (24 * b));
            acz = acz + (AW'(c.ppz[a*RL+b]) << (24 * b));
          end
          n.rwx[a] = acx;
          n.rwz[a] = acz;
        end
        n.ppx = '0;
        n.ppz = '0;
      end else if (j == 2) begin
        for (int a = 0; a < NL; a++) begin
          smx = smx + (PRW'(c.rwx[a]) << (24 * a));
          smz = smz + (PRW'(c.rwz[a]) << (24 * a));
        end
        n.fxq = smx[RS +: cbos_pkg::QUOT_W];
        n.fzq = smz[RS +: cbos_pkg::QUOT_W];
        n.rwx = '0;
        n.rwz = '0;
      end
      if (j < NS) begin
        if (m[DW-1 -: SH] == '0) begin
          n.ax = c.ax << SH;
          n.az = c.az << SH;
        end
      end else if (j == NS) begin
        n.ax  = DW'(a24);
        n.az  = DW'(b24);
        n.sqn = {2'b00, pa};
        n.sq2 = pb;
      end else if (j == NS + 1) begin
        n.sqn = c.sqn + {2'b00, c.sq2};
        n.sqr = '0;
        n.sqq = '0;
      end else if (j < NS + 27) begin
        ge    = r2 >= tq;
        n.sqr = ge ? (r2 - tq) : r2;
        n.sqq = {c.sqq[cbos_pkg::ROOT_W-2:0], ge};
        n.sqn = {c.sqn[47:0], 2'b00};
      end else if (j == NS + 27) begin
        n.dv  = {c.sqq, 1'b0};
        n.oxr = {1'b0, wax, 1'b0} + 42'(c.sqq);
        n.ozr = {1'b0, waz, 1'b0} + 42'(c.sqq);
        n.oxq = '0;
        n.ozq = '0;
      end else begin
        ge    = {1'b0, c.oxr} >= dsh;
        n.oxr = ge ? 42'({1'b0, c.oxr} - dsh) : c.oxr;
        n.oxq = {c.oxq[cbos_pkg::OFS_W-2:0], ge};
        ge    = {1'b0, c.ozr} >= dsh;
        n.ozr = ge ? 42'({1'b0, c.ozr} - dsh) : c.ozr;
        n.ozq = {c.ozq[cbos_pkg::OFS_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ch_r[j+1] <= n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= '0;
      v_r  <= '0;
    end else if (adv) begin
      vp_r <= {vp_r[3:0], in_tvalid};
      v_r  <= {v_r[T-1:0], vp_r[4]};
    end
  end

  ctx_t                 fin;
  logic signed [26:0]   fx, fz, ox, oz, lx, lz, rx, rz;

  assign fin = ch_r[T];

  always_comb begin
    fx = 27'($signed({1'b0, fin.fxq})) - 27'sd16777216;
    fz = 27'($signed({1'b0, fin.fzq})) - 27'sd16777216;
    ox = 27'($signed({1'b0, fin.oxq}));
    oz = 27'($signed({1'b0, fin.ozq}));
    lx = fx;
    lz = fz;
    rx = fx;
    rz = fz;
    if (!fin.deg) begin
      if (fin.zpos) begin
        lx = fx - oz;
        rx = fx + oz;
      end else if (fin.zneg) begin
        lx = fx + oz;
        rx = fx - oz;
      end
      if (fin.xpos) begin
        lz = fz + ox;
        rz = fz - ox;
      end else if (fin.xneg) begin
        lz = fz - ox;
        rz = fz + ox;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= v_r[T];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= {cbos_pkg::sat_coord(rz), cbos_pkg::sat_coord(rx),
                      cbos_pkg::sat_coord(lz), cbos_pkg::sat_coord(lx)};
      out_tuser_r <= fin.deg;
    end
  end

endmodule
